@@ design/stq_pkg.sv @@
// shared types and codes for the sorted timestamp request queue
package stq_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CHECK  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  localparam int unsigned PosBits = 4;

  typedef struct packed {
    logic load;    // capture a request and its per-slot compare flags
    logic commit;  // update the slots and load the result register
  } stq_cmd_t;

endpackage

@@ design/stq_if.sv @@
// request and result channel interfaces

interface stq_req_if #(
  parameter int STAMP_BITS  = 32,
  parameter int SOURCE_BITS = 8,
  parameter int HANDLE_BITS = 16
);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic [STAMP_BITS-1:0]           stamp;
  logic [SOURCE_BITS-1:0]          src;
  logic [HANDLE_BITS-1:0]          handle;
  logic [stq_pkg::PosBits-1:0]     position;

  modport source (output valid, kind, stamp, src, handle, position, input ready);
  modport sink   (input valid, kind, stamp, src, handle, position, output ready);
endinterface

interface stq_rsp_if #(
  parameter int STAMP_BITS  = 32,
  parameter int SOURCE_BITS = 8,
  parameter int HANDLE_BITS = 16,
  parameter int CNT_BITS    = 5
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [STAMP_BITS-1:0]  out_stamp;
  logic [SOURCE_BITS-1:0] out_source;
  logic [HANDLE_BITS-1:0] out_handle;
  logic                   found;
  logic [CNT_BITS-1:0]    occupancy;

  modport source (output valid, status, out_stamp, out_source, out_handle, found, occupancy,
                  input ready);
  modport sink   (input valid, status, out_stamp, out_source, out_handle, found, occupancy,
                  output ready);
endinterface

@@ design/stq_ctrl.sv @@
// controller: request acceptance, commit sequencing and result valid
module stq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output stq_pkg::stq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_COMMIT = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   slot_free;

  // result register can take a new value when empty or being drained
  assign slot_free   = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

@@ design/stq_datapath.sv @@
// datapath: row of compare-and-shift slots, entry count and result register
module stq_datapath #(
  parameter int DEPTH       = 16,
  parameter int STAMP_BITS  = 32,
  parameter int SOURCE_BITS = 8,
  parameter int HANDLE_BITS = 16,
  parameter int CNT_BITS    = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stq_pkg::stq_cmd_t           cmd_i,
  input  logic [1:0]                  kind_i,
  input  logic [STAMP_BITS-1:0]       stamp_i,
  input  logic [SOURCE_BITS-1:0]      source_i,
  input  logic [HANDLE_BITS-1:0]      handle_i,
  input  logic [stq_pkg::PosBits-1:0] position_i,
  output logic [1:0]                  status_o,
  output logic [STAMP_BITS-1:0]       out_stamp_o,
  output logic [SOURCE_BITS-1:0]      out_source_o,
  output logic [HANDLE_BITS-1:0]      out_handle_o,
  output logic                        found_o,
  output logic [CNT_BITS-1:0]         occupancy_o
);

  localparam int PCMP_BITS = (CNT_BITS > stq_pkg::PosBits) ? CNT_BITS : stq_pkg::PosBits;

  logic [STAMP_BITS-1:0]  slot_stamp_q  [DEPTH];
  logic [SOURCE_BITS-1:0] slot_source_q [DEPTH];
  logic [HANDLE_BITS-1:0] slot_handle_q [DEPTH];
  logic [STAMP_BITS-1:0]  slot_stamp_d  [DEPTH];
  logic [SOURCE_BITS-1:0] slot_source_d [DEPTH];
  logic [HANDLE_BITS-1:0] slot_handle_d [DEPTH];

  logic [CNT_BITS-1:0] count_q, count_d;

  // captured request
  stq_pkg::kind_e         kind_q;
  logic [STAMP_BITS-1:0]  stamp_q;
  logic [SOURCE_BITS-1:0] source_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic                   pos_ok_q, full_q;

  // per-slot compare flags, evaluated against the slots at accept time
  logic [DEPTH-1:0] below_d, ge_d, eq_d, match_d;
  logic [DEPTH-1:0] below_q, ge_q, eq_q, match_q;

  logic [PCMP_BITS-1:0] pos_ext, cnt_ext;
  logic                 do_insert, do_remove;

  // result register
  stq_pkg::status_e       status_q;
  logic [STAMP_BITS-1:0]  res_stamp_q, res_stamp_d;
  logic [SOURCE_BITS-1:0] res_source_q, res_source_d;
  logic [HANDLE_BITS-1:0] res_handle_q, res_handle_d;
  logic                   found_q;
  stq_pkg::status_e       status_d;
  logic                   found_d;
  logic [STAMP_BITS-1:0]  sel_stamp;
  logic [SOURCE_BITS-1:0] sel_source;
  logic [HANDLE_BITS-1:0] sel_handle;

  assign pos_ext = PCMP_BITS'(position_i);
  assign cnt_ext = PCMP_BITS'(count_q);

  for (genvar i = 0; i < DEPTH; i++) begin : g_flag
    localparam logic [PCMP_BITS-1:0] Idx = PCMP_BITS'(i);
    logic in_use;
    assign in_use     = Idx < cnt_ext;
    assign below_d[i] = in_use && ((slot_stamp_q[i] < stamp_i) ||
                        ((slot_stamp_q[i] == stamp_i) && (slot_source_q[i] < source_i)));
    assign ge_d[i]    = Idx >= pos_ext;
    assign eq_d[i]    = Idx == pos_ext;
    assign match_d[i] = in_use && (slot_source_q[i] == source_i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= stq_pkg::kind_e'(kind_i);
      stamp_q  <= stamp_i;
      source_q <= source_i;
      handle_q <= handle_i;
      pos_ok_q <= pos_ext < cnt_ext;
      full_q   <= count_q == CNT_BITS'(DEPTH);
      below_q  <= below_d;
      ge_q     <= ge_d;
      eq_q     <= eq_d;
      match_q  <= match_d;
    end
  end

  assign do_insert = (kind_q == stq_pkg::KIND_INSERT) && !full_q;
  assign do_remove = (kind_q == stq_pkg::KIND_REMOVE) && pos_ok_q;

  // each slot looks only at its neighbors and the captured request: insert shifts up, remove shifts down
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic [STAMP_BITS-1:0]  prev_stamp, next_stamp;
    logic [SOURCE_BITS-1:0] prev_source, next_source;
    logic [HANDLE_BITS-1:0] prev_handle, next_handle;
    logic                   take_new;

    if (i == 0) begin : g_first
      assign prev_stamp  = stamp_q;
      assign prev_source = source_q;
      assign prev_handle = handle_q;
      assign take_new    = 1'b1;
    end else begin : g_inner
      assign prev_stamp  = slot_stamp_q[i-1];
      assign prev_source = slot_source_q[i-1];
      assign prev_handle = slot_handle_q[i-1];
      assign take_new    = below_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_stamp  = slot_stamp_q[i];
      assign next_source = slot_source_q[i];
      assign next_handle = slot_handle_q[i];
    end else begin : g_mid
      assign next_stamp  = slot_stamp_q[i+1];
      assign next_source = slot_source_q[i+1];
      assign next_handle = slot_handle_q[i+1];
    end

    always_comb begin
      slot_stamp_d[i]  = slot_stamp_q[i];
      slot_source_d[i] = slot_source_q[i];
      slot_handle_d[i] = slot_handle_q[i];
      if (do_insert && !below_q[i]) begin
        if (take_new) begin
          slot_stamp_d[i]  = stamp_q;
          slot_source_d[i] = source_q;
          slot_handle_d[i] = handle_q;
        end else begin
          slot_stamp_d[i]  = prev_stamp;
          slot_source_d[i] = prev_source;
          slot_handle_d[i] = prev_handle;
        end
      end else if (do_remove && ge_q[i]) begin
        slot_stamp_d[i]  = next_stamp;
        slot_source_d[i] = next_source;
        slot_handle_d[i] = next_handle;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.commit) begin
        slot_stamp_q[i]  <= slot_stamp_d[i];
        slot_source_q[i] <= slot_source_d[i];
        slot_handle_q[i] <= slot_handle_d[i];
      end
    end
  end

  // slot at the requested index, one-hot select
  always_comb begin
    sel_stamp  = '0;
    sel_source = '0;
    sel_handle = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (eq_q[i]) begin
        sel_stamp  = sel_stamp  | slot_stamp_q[i];
        sel_source = sel_source | slot_source_q[i];
        sel_handle = sel_handle | slot_handle_q[i];
      end
    end
  end

  always_comb begin
    status_d     = stq_pkg::ST_OK;
    res_stamp_d  = '0;
    res_source_d = '0;
    res_handle_d = '0;
    found_d      = 1'b0;
    count_d      = count_q;
    case (kind_q)
      stq_pkg::KIND_INSERT: begin
        if (full_q) begin
          status_d = stq_pkg::ST_FULL;
        end else begin
          count_d = count_q + CNT_BITS'(1);
        end
      end
      stq_pkg::KIND_REMOVE, stq_pkg::KIND_READ: begin
        if (!pos_ok_q) begin
          status_d = stq_pkg::ST_RANGE;
        end else begin
          res_stamp_d  = sel_stamp;
          res_source_d = sel_source;
          res_handle_d = sel_handle;
          if (kind_q == stq_pkg::KIND_REMOVE) begin
            count_d = count_q - CNT_BITS'(1);
          end
        end
      end
      stq_pkg::KIND_CHECK: found_d = |match_q;
      default: status_d = stq_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q     <= status_d;
      res_stamp_q  <= res_stamp_d;
      res_source_q <= res_source_d;
      res_handle_q <= res_handle_d;
      found_q      <= found_d;
    end
  end

  assign status_o     = status_q;
  assign out_stamp_o  = res_stamp_q;
  assign out_source_o = res_source_q;
  assign out_handle_o = res_handle_q;
  assign found_o      = found_q;
  assign occupancy_o  = count_q;

endmodule

@@ design/sorted_timestamp_request_queue_top.sv @@
// top level of the sorted timestamp request queue
//
// Holds up to DEPTH entries (timestamp, source, handle) kept in ascending
// order of timestamp, ties by ascending source; a new entry goes ahead of
// entries with an equal key. Requests arrive on req_i (valid/ready) and each
// gives exactly one result on rsp_o (valid/ready): insert, remove at index,
// read at index, or presence check by source.
// A request is accepted only in the idle state; at that edge every slot
// compares itself against the request. At the commit edge, once the result
// register is free, the slot row shifts in one step and the result register
// is loaded, raising rsp_o.valid. An item passes the capture edge and then
// the commit edge of the compare-and-shift slot row.
// The next request may be taken while a result still waits in the output
// register; if the receiver stalls, the following commit waits until that
// result is taken, and req_i.ready stays low meanwhile.
// Reset empties the queue (occupancy zero) and drops any pending result;
// slot contents are not cleared and are never read while unused.
module sorted_timestamp_request_queue_top #(
  parameter int DEPTH       = 16,
  parameter int STAMP_BITS  = 32,
  parameter int SOURCE_BITS = 8,
  parameter int HANDLE_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  stq_req_if.sink  req_i,
  stq_rsp_if.source rsp_o
);

  localparam int CNT_BITS = $clog2(DEPTH + 1);

  stq_pkg::stq_cmd_t cmd;

  stq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  stq_datapath #(
    .DEPTH       (DEPTH),
    .STAMP_BITS  (STAMP_BITS),
    .SOURCE_BITS (SOURCE_BITS),
    .HANDLE_BITS (HANDLE_BITS),
    .CNT_BITS    (CNT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_i       (req_i.kind),
    .stamp_i      (req_i.stamp),
    .source_i     (req_i.src),
    .handle_i     (req_i.handle),
    .position_i   (req_i.position),
    .status_o     (rsp_o.status),
    .out_stamp_o  (rsp_o.out_stamp),
    .out_source_o (rsp_o.out_source),
    .out_handle_o (rsp_o.out_handle),
    .found_o      (rsp_o.found),
    .occupancy_o  (rsp_o.occupancy)
  );

endmodule

@@ design/stq_checker.sv @@
// port-level checks for the sorted timestamp request queue, with bind
module stq_port_checks #(
  parameter int DEPTH    = 16,
  parameter int CNT_BITS = 5
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [1:0]          status_i,
  input logic                any_payload_i,
  input logic                found_i,
  input logic [CNT_BITS-1:0] occupancy_i
);

  // a stalled result keeps its status and occupancy
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) && $stable(occupancy_i))
    else $error("result changed while stalled");

  // one request in flight: ready goes low after each transfer
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken during commit");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> occupancy_i <= CNT_BITS'(DEPTH))
    else $error("occupancy above capacity");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == stq_pkg::ST_FULL |-> occupancy_i == CNT_BITS'(DEPTH))
    else $error("full refusal with room left");

  // a refused index returns no entry data and no found flag
  a_range_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == stq_pkg::ST_RANGE |-> !any_payload_i && !found_i)
    else $error("entry data on index refusal");

endmodule

bind sorted_timestamp_request_queue_top stq_port_checks #(
  .DEPTH    (DEPTH),
  .CNT_BITS (CNT_BITS)
) u_stq_port_checks (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .any_payload_i ((|rsp_o.out_stamp) || (|rsp_o.out_source) || (|rsp_o.out_handle)),
  .found_i       (rsp_o.found),
  .occupancy_i   (rsp_o.occupancy)
);
